@@ rtl/core/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types for the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  // Longest pattern the cell row can hold; one cell per pattern position.
  localparam int MAX_PATTERN = 32;
  // Width of the byte counter within a region.
  localparam int OFFSET_BITS = 32;
  // Width of the reported start offset.
  localparam int OFS_W       = 32;
  // Width of the pattern length register.
  localparam int LEN_W       = 6;
  // Widest configuration register.
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PAT_WORDS   = 4;

  typedef logic [OFFSET_BITS-1:0] cnt_t;
  typedef logic [LEN_W-1:0]       len_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_WILD = 3'd4,
    REG_LEN  = 3'd5
  } cfg_reg_t;

  // One result beat.
  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] offset;
  } wbps_res_t;

endpackage

`default_nettype wire

@@ rtl/core/wildcard_byte_pattern_search.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Scans a byte region for the first offset where a wildcard pattern matches.
//
// Usage: one region byte enters per in_ beat, in_tlast marking the region's
// final byte. The pattern (up to 32 bytes), the wildcard mask and the
// pattern length are written through the cfg_ port while the block is idle.
// Each region yields exactly one out_ beat: out_tuser = 1 with the start
// offset in out_tdata at the first full match, or out_tuser = 0 with a zero
// offset on the last byte when nothing matched. Bytes after a match are
// consumed silently until in_tlast, which clears the region state.
// Throughput is one byte per cycle while in_tready is high: a row of 32 cells, one per pattern
// position, updates the whole partial match vector on every byte.
// The result of the deciding byte is registered before out_tvalid shows it.
// Results go through an output register plus a skid register, so input
// stays ready while one result waits; in_tready drops only when two results
// are held, and returns as soon as the receiver takes one.
// Reset (rst_n low at a clock edge) clears all pattern registers, the
// region state and any held results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_search (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wbps_pkg::CFG_W-1:0]          cfg_data,
  // Byte stream in.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  wire logic                                in_tlast,   // last_byte
  // Results out.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [wbps_pkg::OFS_W-1:0]               out_tdata,  // [31:0] match_offset
  output logic                                     out_tuser   // [0] found
);

  logic [wbps_pkg::PAT_WORDS-1:0][wbps_pkg::CFG_W-1:0] pat_r;
  logic [wbps_pkg::MAX_PATTERN-1:0]                    wild_r;
  wbps_pkg::len_t                                      len_r;

  wbps_pkg::cnt_t cnt_r;
  wbps_pkg::cnt_t cnt_nxt;
  logic           rep_r;
  logic           rep_nxt;

  wbps_pkg::len_t                   alen;
  logic                             fire;
  logic                             step;
  logic                             clear;
  logic                             found;
  logic                             res_push;
  wbps_pkg::wbps_res_t              res;
  wbps_pkg::wbps_res_t              out_res;
  logic [wbps_pkg::MAX_PATTERN-1:0] chain;
  logic [wbps_pkg::MAX_PATTERN-1:0] hits;
  logic                             buf_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      wild_r <= '0;
      len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_PAT0: pat_r[0] <= cfg_data;
        wbps_pkg::REG_PAT1: pat_r[1] <= cfg_data;
        wbps_pkg::REG_PAT2: pat_r[2] <= cfg_data;
        wbps_pkg::REG_PAT3: pat_r[3] <= cfg_data;
        wbps_pkg::REG_WILD: wild_r <= cfg_data[wbps_pkg::MAX_PATTERN-1:0];
        wbps_pkg::REG_LEN:  len_r  <= cfg_data[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign alen = (len_r > wbps_pkg::len_t'(wbps_pkg::MAX_PATTERN))
              ? wbps_pkg::len_t'(wbps_pkg::MAX_PATTERN) : len_r;

  assign in_tready = buf_ready;
  assign fire      = in_tvalid & in_tready;
  // A byte at the saturated counter value no longer advances the vector.
  assign step      = fire & ~rep_r & (cnt_r != '1);
  assign clear     = fire & in_tlast;

  genvar gi;
  generate
    for (gi = 0; gi < wbps_pkg::MAX_PATTERN; gi++) begin : g_cell
      logic cin;
      if (gi == 0) begin : g_head
        assign cin = 1'b1;
      end else begin : g_link
        assign cin = chain[gi-1];
      end
      wbps_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .clear     (clear),
        .chain_in  (cin),
        .data_byte (in_tdata),
        .pat_byte  (pat_r[gi/8][(gi%8)*8 +: 8]),
        .wild      (wild_r[gi]),
        .en        (wbps_pkg::len_t'(gi) < alen),
        .tail      (alen == wbps_pkg::len_t'(gi + 1)),
        .chain_out (chain[gi]),
        .hit       (hits[gi])
      );
    end
  endgenerate

  assign found    = step & (|hits);
  assign res_push = fire & ~rep_r & (found | in_tlast);

  always_comb begin
    res.found  = found;
    res.offset = '0;
    if (found) begin
      res.offset = wbps_pkg::OFS_W'(cnt_r - wbps_pkg::cnt_t'(alen - wbps_pkg::len_t'(1)));
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rep_nxt = rep_r;
    if (clear) begin
      cnt_nxt = '0;
      rep_nxt = 1'b0;
    end else begin
      if (step) begin
        cnt_nxt = cnt_r + wbps_pkg::cnt_t'(1);
      end
      if (found) begin
        rep_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rep_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rep_r <= rep_nxt;
    end
  end

  wbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_res  (res),
    .can_push  (buf_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.offset;
  assign out_tuser = out_res.found;

endmodule

`default_nettype wire

@@ rtl/core/wbps_cell.sv @@
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern position: holds its partial match bit and extends the match
// handed over by the previous position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,      // a byte advances the vector
  input  wire logic       clear,     // end of region
  input  wire logic       chain_in,  // previous position's bit before this byte
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] pat_byte,
  input  wire logic       wild,
  input  wire logic       en,        // position lies below the active length
  input  wire logic       tail,      // position is the last one of the pattern
  output logic            chain_out,
  output logic            hit
);

  logic bit_r;
  logic bit_nxt;
  logic accept;

  assign accept    = en & (wild | (pat_byte == data_byte));
  assign bit_nxt   = chain_in & accept;
  assign chain_out = bit_r;
  assign hit       = bit_nxt & tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else if (clear) begin
      bit_r <= 1'b0;
    end else if (step) begin
      bit_r <= bit_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wbps_out_buf.sv @@
// ----------------------------------------------------------------------------
// wbps_out_buf
// Two-entry result buffer: an output register backed by a skid register so
// the scanner keeps taking bytes while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbps_out_buf (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire wbps_pkg::wbps_res_t      push_res,
  output logic                          can_push,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output wbps_pkg::wbps_res_t           out_res
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                skid_valid_r;
  logic                skid_valid_nxt;
  wbps_pkg::wbps_res_t out_res_r;
  wbps_pkg::wbps_res_t out_res_nxt;
  wbps_pkg::wbps_res_t skid_res_r;
  wbps_pkg::wbps_res_t skid_res_nxt;
  logic                pop;

  assign pop       = out_valid_r & out_ready;
  assign can_push  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || pop) begin
      // The output register is free; the skid entry is older than a new push.
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

`default_nettype wire

@@ tb/wbps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_checker
// Watches the configuration port and both streams of the wildcard byte
// pattern search block, predicts the result of every region and checks
// each result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

module wbps_checker
  import wbps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] data_byte
  input  wire logic                 in_tlast,   // last_byte
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [OFS_W-1:0]     out_tdata,  // [31:0] match_offset
  input  wire logic                 out_tuser,  // [0] found
  output int                        fail_count,
  output int                        pending,
  output int                        bytes_seen,
  output int                        results_seen,
  output int                        matches_seen
);

  // Mirror of the programmed search.
  logic [CFG_W-1:0]       pat_word [PAT_WORDS];
  logic [31:0]            wild;
  len_t                   plen;

  // Region state: bit i of prefix_hits means positions 0..i match the bytes
  // that end at the current one.
  logic [MAX_PATTERN-1:0] prefix_hits;
  cnt_t                   byte_idx;
  logic                   region_done;

  wbps_res_t              verdict_q [$];
  int                     fails;
  int                     nbytes;
  int                     nresults;
  int                     nmatches;

  function automatic logic [MAX_PATTERN-1:0] accepting_positions(input logic [7:0] b,
                                                                  input int n);
    logic [MAX_PATTERN-1:0] m;
    logic [7:0]             pb;
    m = '0;
    for (int i = 0; i < n; i++) begin
      pb = pat_word[i / 8][8 * (i % 8) +: 8];
      if (wild[i] || pb == b) m[i] = 1'b1;
    end
    return m;
  endfunction

  function automatic void clear_region();
    prefix_hits = '0;
    byte_idx    = '0;
    region_done = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic is_last);
    int        n;
    logic      hit;
    wbps_res_t want;
    hit = 1'b0;
    if (!region_done) begin
      n = (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
      // A saturated counter freezes the search for the rest of the region.
      if (byte_idx != '1) begin
        prefix_hits = ((prefix_hits << 1) | 1'b1) & accepting_positions(b, n);
        if (n > 0 && prefix_hits[n - 1]) begin
          want.found  = 1'b1;
          want.offset = OFS_W'(byte_idx - cnt_t'(n - 1));
          verdict_q.insert(verdict_q.size(), want);
          region_done = 1'b1;
          hit         = 1'b1;
        end
        byte_idx = byte_idx + 1'b1;
      end
      if (is_last && !hit) begin
        want.found  = 1'b0;
        want.offset = '0;
        verdict_q.insert(verdict_q.size(), want);
      end
    end
    if (is_last) clear_region();
  endfunction

  always @(posedge clk) begin
    wbps_res_t want;
    if (!rst_n) begin
      foreach (pat_word[k]) pat_word[k] = '0;
      wild = '0;
      plen = '0;
      clear_region();
      verdict_q.delete();
      fails    = 0;
      nbytes   = 0;
      nresults = 0;
      nmatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        nresults++;
        if (out_tuser) nmatches++;
        if (verdict_q.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, found %0b offset %0d",
                   $time, out_tuser, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (out_tuser !== want.found) begin
            fails++;
            $display("%0t: found expected %0b, got %0b", $time, want.found, out_tuser);
          end
          if (out_tdata !== want.offset) begin
            fails++;
            $display("%0t: match_offset expected %0d, got %0d", $time, want.offset,
                     out_tdata);
          end
        end
      end
      // A byte taken at the same edge as a write still sees the old setting.
      if (in_tvalid && in_tready) begin
        nbytes++;
        scan_byte(in_tdata, in_tlast);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_word[cfg_index[1:0]] = cfg_data;
          REG_WILD: wild = cfg_data[31:0];
          REG_LEN:  plen = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count   <= fails;
    pending      <= verdict_q.size();
    bytes_seen   <= nbytes;
    results_seen <= nresults;
    matches_seen <= nmatches;
  end

endmodule

@@ tb/wildcard_byte_pattern_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_tb
// Drives byte regions and pattern settings into the search block: a short
// directed set of corner regions, then random settings with regions that
// mostly carry a planted copy of the pattern. The sender runs in bursts, the
// receiver stalls on its own schedule, and a separate checker judges results.
// ----------------------------------------------------------------------------

module wildcard_byte_pattern_search_tb;
  import wbps_pkg::*;

  localparam int ITEM_TARGET   = 1750;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 3000;
  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;
  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_FEW} fill_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tready = 1'b0;
  wire logic            in_tready;
  wire logic            out_tvalid;
  wire logic [OFS_W-1:0] out_tdata;
  wire logic            out_tuser;

  int fail_count, pending, bytes_seen, results_seen, matches_seen;

  // Setting currently being programmed, kept to build matching regions.
  logic [7:0]       pat_b [MAX_PATTERN];
  logic [31:0]      wild_b;
  logic [LEN_W-1:0] len_b;
  logic [7:0]       region_q [$];

  int items_sent      = 0;
  int regions_sent    = 0;
  int settings_loaded = 0;
  int burst_left      = 0;
  bit bursty          = 1'b0;
  int hold_asked      = 0;
  int hold_served     = 0;
  int quiet_cycles    = 0;

  wildcard_byte_pattern_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  wbps_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .bytes_seen   (bytes_seen),
    .results_seen (results_seen),
    .matches_seen (matches_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The run ends if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall modes change at random from one span to the next, and a
  // requested hold keeps out_tready low long enough for the block to back up.
  initial begin
    rx_mode_t mode;
    int       span;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(32, 200);
      repeat (span) begin
        @(posedge clk);
        if (hold_asked != hold_served) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_served++;
        end
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Upper bits of the narrow registers carry junk that the block must drop.
  task automatic load_pattern(input bit with_spare);
    cfg_reg_t         pat_regs [PAT_WORDS] = '{REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3};
    logic [CFG_W-1:0] w;
    for (int k = 0; k < PAT_WORDS; k++) begin
      for (int j = 0; j < 8; j++) w[8 * j +: 8] = pat_b[8 * k + j];
      write_reg(pat_regs[k], w);
    end
    write_reg(REG_WILD, {32'($urandom), wild_b});
    write_reg(REG_LEN, {26'($urandom), 32'($urandom), len_b});
    if (with_spare) begin
      write_reg(REG_SPARE_LO, '1);
      write_reg(REG_SPARE_HI, {32'($urandom), 32'($urandom)});
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Valid is left high after a beat unless a gap follows, so back-to-back
  // bytes never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (bursty) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 24);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic send_region(input bit close);
    foreach (region_q[i]) send_byte(region_q[i], close && (i == region_q.size() - 1));
    if (close) regions_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int active_len();
    return (len_b > MAX_PATTERN) ? MAX_PATTERN : int'(len_b);
  endfunction

  // Random bytes drawn half from the pattern itself, with one copy of the
  // pattern planted on request; wildcard positions keep random content.
  task automatic make_region(input int rlen, input bit plant);
    int n;
    int at;
    n = active_len();
    region_q.delete();
    for (int i = 0; i < rlen; i++) begin
      if (n > 0 && $urandom_range(0, 1) == 1) begin
        region_q.insert(region_q.size(), pat_b[$urandom_range(0, n - 1)]);
      end else begin
        region_q.insert(region_q.size(), 8'($urandom));
      end
    end
    if (plant && n > 0 && rlen >= n) begin
      at = $urandom_range(0, rlen - n);
      for (int i = 0; i < n; i++) begin
        if (!wild_b[i]) region_q[at + i] = pat_b[i];
      end
    end
  endtask

  task automatic pick_setting();
    logic [7:0] few [3] = '{8'h00, 8'hFF, 8'h5A};
    fill_t      fill;
    int         pick;
    fill = fill_t'($urandom_range(0, 3));
    foreach (pat_b[i]) begin
      case (fill)
        FILL_ZERO:   pat_b[i] = 8'h00;
        FILL_ONES:   pat_b[i] = 8'hFF;
        FILL_RANDOM: pat_b[i] = 8'($urandom);
        default:     pat_b[i] = few[$urandom_range(0, 2)];
      endcase
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) len_b = '0;
    else if (pick == 1) len_b = LEN_W'(MAX_PATTERN);
    else if (pick == 2) len_b = LEN_W'($urandom_range(MAX_PATTERN + 1, 63));
    else if (pick < 5) len_b = LEN_W'($urandom_range(9, MAX_PATTERN - 1));
    else len_b = LEN_W'($urandom_range(1, 8));
    pick = $urandom_range(0, 9);
    if (pick == 0) wild_b = '1;
    else if (pick < 4) wild_b = '0;
    else wild_b = $urandom & $urandom;
  endtask

  initial begin
    int nreg;
    int rlen;
    int n;
    bit open_region;
    bit pressure;
    open_region = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset leaves the length at zero, so this region cannot match.
    region_q = '{8'h00, 8'hFF, 8'h00};
    send_region(1'b1);
    wait_idle();

    // Four-byte pattern with a wildcard in the third position.
    foreach (pat_b[i]) pat_b[i] = 8'($urandom);
    pat_b[0] = 8'h41;
    pat_b[1] = 8'h42;
    pat_b[2] = 8'h00;
    pat_b[3] = 8'h44;
    wild_b   = 32'h0000_0004;
    len_b    = LEN_W'(4);
    load_pattern(1'b1);
    // Match that completes on the last byte.
    region_q = '{8'h41, 8'h42, 8'h99, 8'h44};
    send_region(1'b1);
    // Match at offset one, followed by bytes that must be swallowed.
    region_q = '{8'h00, 8'h41, 8'h42, 8'hFF, 8'h44, 8'h77, 8'h55};
    send_region(1'b1);
    // Regions shorter than the pattern.
    region_q = '{8'h41, 8'h42};
    send_region(1'b1);
    region_q = '{8'hFF};
    send_region(1'b1);
    wait_idle();

    // All positions wild: hit at offset zero once enough bytes are in.
    wild_b = '1;
    len_b  = LEN_W'(3);
    load_pattern(1'b0);
    region_q = '{8'h00, 8'hFF, 8'h12, 8'h34, 8'h56};
    send_region(1'b1);
    wait_idle();

    while (items_sent < ITEM_TARGET) begin
      // An open region from the last setting continues under the new one.
      pick_setting();
      load_pattern($urandom_range(0, 7) == 0);
      n        = active_len();
      bursty   = ($urandom_range(0, 2) != 0);
      pressure = (settings_loaded % 25 == 4);
      if (pressure) hold_asked++;
      nreg = pressure ? 24 : $urandom_range(3, 10);
      for (int r = 0; r < nreg; r++) begin
        if (pressure) rlen = $urandom_range(1, 3);
        else if (n >= 16) rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n)
                                                             : $urandom_range(n, n + 12);
        else if ($urandom_range(0, 15) == 0) rlen = $urandom_range(40, 90);
        else rlen = $urandom_range(1, 3 * n + 6);
        make_region(rlen, $urandom_range(0, 9) < 6);
        open_region = (r == nreg - 1) && ($urandom_range(0, 3) == 0);
        send_region(!open_region);
      end
      wait_idle();
    end

    if (open_region) begin
      region_q = '{8'($urandom)};
      send_region(1'b1);
      wait_idle();
    end

    $display("tb: scanned %0d bytes in %0d closed regions under %0d pattern settings",
             bytes_seen, regions_sent, settings_loaded);
    $display("tb: compared %0d result beats, %0d of them reporting a match",
             results_seen, matches_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ wildcard_byte_pattern_search.f @@
rtl/core/wbps_pkg.sv
rtl/core/wbps_cell.sv
rtl/core/wbps_out_buf.sv
rtl/core/wildcard_byte_pattern_search.sv
tb/wbps_checker.sv
tb/wildcard_byte_pattern_search_tb.sv
